// File: src/cmb_enum_pkg.sv
// ----------------------------------------------------------------------------
// Combination enumerator package
// Shared widths, register indexes, controller states and the command and
// status words that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package cmb_enum_pkg;

    localparam int ELEM_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PICK_COUNT = 2'd1;

    localparam logic [CFG_DATA_W-1:0] SET_SIZE_RST   = 4'd4;
    localparam logic [CFG_DATA_W-1:0] PICK_COUNT_RST = 4'd2;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EMIT   = 4'b0010,
        S_REFILL = 4'b0100,
        S_FINAL  = 4'b1000
    } t_state;

    typedef struct packed {
        logic load;
        logic start_emit;
        logic emit;
        logic start_refill;
        logic refill;
        logic emit_final;
        logic set_exh;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic started;
        logic exhausted;
        logic m_gt_n;
        logic m_zero;
        logic ptr_last;
        logic found_now;
    } t_dp_status;

endpackage

// File: src/cmb_enum_if.sv
// ----------------------------------------------------------------------------
// Combination enumerator channels
// Request, result and register write channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface cmb_enum_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface cmb_enum_out_if;
    logic                            valid;
    logic                            ready;
    logic [cmb_enum_pkg::ELEM_W-1:0] element;
    logic                            last_in_set;
    logic                            empty_set;
    logic                            finished;

    modport source (output valid, output element, output last_in_set,
                    output empty_set, output finished, input ready);
    modport sink   (input valid, input element, input last_in_set,
                    input empty_set, input finished, output ready);
endinterface

interface cmb_enum_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [cmb_enum_pkg::CFG_IDX_W-1:0]  index;
    logic [cmb_enum_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/cmb_enum_ctrl.sv
// ----------------------------------------------------------------------------
// Combination enumerator controller
// Sequences request decoding, element emission and the refill of the
// index registers after the successor position has been found.
// ----------------------------------------------------------------------------
module cmb_enum_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    cmb_enum_in_if.sink              i_in,
    input  cmb_enum_pkg::t_dp_status i_status,
    output cmb_enum_pkg::t_dp_cmd    o_cmd
);

    cmb_enum_pkg::t_state r_state;
    cmb_enum_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cmb_enum_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        i_in.ready = 1'b0;
        unique case (r_state)
            cmb_enum_pkg::S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    o_cmd.load = i_in.restart || !i_status.started;
                    if (!i_in.restart) begin
                        if ((i_status.started && i_status.exhausted) ||
                            i_status.m_gt_n || i_status.m_zero) begin
                            n_state = cmb_enum_pkg::S_FINAL;
                        end else begin
                            o_cmd.start_emit = 1'b1;
                            n_state          = cmb_enum_pkg::S_EMIT;
                        end
                    end
                end
            end
            cmb_enum_pkg::S_FINAL: begin
                if (i_status.out_free) begin
                    o_cmd.emit_final = 1'b1;
                    n_state          = cmb_enum_pkg::S_IDLE;
                end
            end
            cmb_enum_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.ptr_last) begin
                        if (i_status.found_now) begin
                            o_cmd.start_refill = 1'b1;
                            n_state            = cmb_enum_pkg::S_REFILL;
                        end else begin
                            o_cmd.set_exh = 1'b1;
                            n_state       = cmb_enum_pkg::S_IDLE;
                        end
                    end
                end
            end
            cmb_enum_pkg::S_REFILL: begin
                o_cmd.refill = 1'b1;
                if (i_status.ptr_last) begin
                    n_state = cmb_enum_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cmb_enum_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: src/cmb_enum_dp.sv
// ----------------------------------------------------------------------------
// Combination enumerator datapath
// Holds the register settings, the index registers of the current
// combination, the walking pointer and the output word register.
// ----------------------------------------------------------------------------
module cmb_enum_dp #(
    parameter int MAX_N = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    cmb_enum_cfg_if.sink              i_cfg,
    cmb_enum_out_if.source            o_out,
    input  cmb_enum_pkg::t_dp_cmd     i_cmd,
    output cmb_enum_pkg::t_dp_status  o_status
);

    localparam int CW = $clog2(MAX_N + 1);
    localparam int SW = (CW > cmb_enum_pkg::CFG_DATA_W) ? CW : cmb_enum_pkg::CFG_DATA_W;
    localparam int PW = (MAX_N > 1) ? $clog2(MAX_N) : 1;

    logic [cmb_enum_pkg::CFG_DATA_W-1:0] r_set_size;
    logic [cmb_enum_pkg::CFG_DATA_W-1:0] r_pick_count;
    logic                                r_started;
    logic                                r_exhausted;
    logic [CW-1:0]                       r_idx [MAX_N];
    logic [PW-1:0]                       r_ptr;
    logic [PW-1:0]                       r_pos;
    logic                                r_found;
    logic                                r_first;
    logic [CW-1:0]                       r_fill;
    logic                                r_out_valid;
    logic [cmb_enum_pkg::ELEM_W-1:0]     r_element;
    logic                                r_last;
    logic                                r_empty;
    logic                                r_finished;

    logic [SW-1:0] n_ext;
    logic [SW-1:0] m_ext;
    logic [CW-1:0] eff_n;
    logic [CW-1:0] eff_m;
    logic [CW-1:0] rd;
    logic [CW-1:0] wdata;
    logic [CW-1:0] ptr_plus1;
    logic [CW:0]   lhs;
    logic [CW:0]   rhs;
    logic          below_limit;
    logic          found_now;
    logic [PW-1:0] pos_now;
    logic          cfg_hit;
    logic          out_free;
    logic          fin_kind;

    assign n_ext = SW'(r_set_size);
    assign m_ext = SW'(r_pick_count);
    assign eff_n = (n_ext > SW'(MAX_N)) ? CW'(MAX_N) : CW'(n_ext);
    assign eff_m = (m_ext > SW'(MAX_N)) ? CW'(MAX_N) : CW'(m_ext);

    assign rd        = r_idx[r_ptr];
    assign ptr_plus1 = CW'(r_ptr) + CW'(1);

    // The position may still grow while idx + m < n + 1 + pos.
    assign lhs         = (CW+1)'(rd) + (CW+1)'(eff_m);
    assign rhs         = (CW+1)'(eff_n) + (CW+1)'(ptr_plus1);
    assign below_limit = lhs < rhs;
    assign found_now   = below_limit || r_found;
    assign pos_now     = below_limit ? r_ptr : r_pos;

    assign wdata    = r_first ? (rd + CW'(1)) : (r_fill + CW'(1));
    assign out_free = !r_out_valid || o_out.ready;
    assign fin_kind = r_exhausted || (eff_m > eff_n);

    always_comb begin
        cfg_hit = 1'b0;
        unique case (i_cfg.index)
            cmb_enum_pkg::CFG_SET_SIZE:   cfg_hit = i_cfg.valid;
            cmb_enum_pkg::CFG_PICK_COUNT: cfg_hit = i_cfg.valid;
            default:                      cfg_hit = 1'b0;
        endcase
    end

    assign i_cfg.ready = 1'b1;

    assign o_status.out_free  = out_free;
    assign o_status.started   = r_started;
    assign o_status.exhausted = r_exhausted;
    assign o_status.m_gt_n    = eff_m > eff_n;
    assign o_status.m_zero    = eff_m == '0;
    assign o_status.ptr_last  = ptr_plus1 == eff_m;
    assign o_status.found_now = found_now;

    assign o_out.valid       = r_out_valid;
    assign o_out.element     = r_element;
    assign o_out.last_in_set = r_last;
    assign o_out.empty_set   = r_empty;
    assign o_out.finished    = r_finished;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_size   <= cmb_enum_pkg::SET_SIZE_RST;
            r_pick_count <= cmb_enum_pkg::PICK_COUNT_RST;
            r_started    <= 1'b0;
            r_exhausted  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg.valid && (i_cfg.index == cmb_enum_pkg::CFG_SET_SIZE)) begin
                r_set_size <= i_cfg.data;
            end
            if (i_cfg.valid && (i_cfg.index == cmb_enum_pkg::CFG_PICK_COUNT)) begin
                r_pick_count <= i_cfg.data;
            end
            if (cfg_hit) begin
                r_started   <= 1'b0;
                r_exhausted <= 1'b0;
            end else if (i_cmd.load) begin
                r_started   <= 1'b1;
                r_exhausted <= 1'b0;
            end else if (i_cmd.emit_final || i_cmd.set_exh) begin
                r_exhausted <= 1'b1;
            end
            if (i_cmd.emit || i_cmd.emit_final) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < MAX_N; i++) begin
                r_idx[i] <= CW'(i + 1);
            end
        end else if (i_cmd.refill) begin
            r_idx[r_ptr] <= wdata;
        end

        if (i_cmd.start_emit) begin
            r_ptr   <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.start_refill) begin
            r_ptr   <= pos_now;
            r_first <= 1'b1;
        end else if (i_cmd.emit) begin
            r_ptr   <= r_ptr + PW'(1);
            r_found <= found_now;
            r_pos   <= pos_now;
        end else if (i_cmd.refill) begin
            r_ptr   <= r_ptr + PW'(1);
            r_fill  <= wdata;
            r_first <= 1'b0;
        end

        if (i_cmd.emit) begin
            r_element  <= cmb_enum_pkg::ELEM_W'(rd);
            r_last     <= ptr_plus1 == eff_m;
            r_empty    <= 1'b0;
            r_finished <= 1'b0;
        end else if (i_cmd.emit_final) begin
            r_element  <= '0;
            r_last     <= 1'b1;
            r_empty    <= !fin_kind;
            r_finished <= fin_kind;
        end
    end

endmodule

// File: src/combination_enumerator_core.sv
// ----------------------------------------------------------------------------
// Combination enumerator core
// Lists the m-element subsets of {1..n} in lexicographic order, one element
// per output word, smallest element first.
// ----------------------------------------------------------------------------
// Usage: registers set_size (index 0) and pick_count (index 1) are to be
// written on i_cfg by the user only while the block is idle, which the block
// does not enforce; a write clears the enumeration so that the next request
// begins at {1..m}. Values above MAX_N are saturated. A request word on i_in
// with restart high reloads {1..m} and gives no output. With restart low the
// current combination leaves on o_out as m words, the final one marked by
// last_in_set, and the successor is formed. An empty pick count gives one
// empty_set word, and a request with nothing left gives one finished word.
// Timing: the request is taken in the idle state, then one element leaves per
// cycle from the single read port of the index registers while the receiver
// takes words, followed by the refill of the index registers from the bumped
// position up to the last one in use. No new request is taken until the block
// is idle again; a finished or empty_set word is sent from its own state. A
// stalled receiver holds the output register and the walk pauses with it.
// After reset the settings are n = 4 and m = 2 and the block is idle.
// ----------------------------------------------------------------------------
module combination_enumerator_core #(
    parameter int MAX_N = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cmb_enum_in_if.sink      i_in,
    cmb_enum_out_if.source   o_out,
    cmb_enum_cfg_if.sink     i_cfg
);

    cmb_enum_pkg::t_dp_cmd    cmd;
    cmb_enum_pkg::t_dp_status status;

    cmb_enum_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_status (status),
        .o_cmd    (cmd)
    );

    cmb_enum_dp #(
        .MAX_N (MAX_N)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .o_out    (o_out),
        .i_cmd    (cmd),
        .o_status (status)
    );

    a_busy_after_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && !i_in.restart) |=> !i_in.ready)
        else $error("Request port ready while a request is in progress.");

    a_ready_after_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.restart) |=> i_in.ready)
        else $error("Restart did not complete in one cycle.");

    a_special_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.finished || o_out.empty_set)) |->
        (o_out.last_in_set && (o_out.element == '0) &&
         !(o_out.finished && o_out.empty_set)))
        else $error("Malformed finished or empty set word.");

endmodule
